/* rtl/wacc_pkg.sv */
package wacc_pkg;

    // Fixed formats of the sample, the sums and the weights.
    localparam int SMP_W     = 16;
    localparam int SUM_W     = 48;
    localparam int TW_W      = 40;
    localparam int FRAC_BITS = 8;
    localparam int NCOMP     = 6;
    localparam int NPRI      = 4;
    localparam int IDX_W     = 3;

    // Mean fraction w is unsigned Q1.16 held in 17 bits.
    localparam int Q_W       = 17;
    localparam int DIV_STEPS = Q_W;
    localparam int CNT_W     = 5;

    // Shared multiplier operands and product.
    localparam int MUL_W  = 18;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [SMP_W-1:0] SAMPLE_WEIGHT_RST = 16'd256;

    localparam logic signed [MUL_W-1:0]  UNIT_WEIGHT = MUL_W'(1 << FRAC_BITS);
    localparam logic signed [PROD_W-1:0] ACC_HALF    = PROD_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [PROD_W-1:0] MEAN_HALF   = PROD_W'(1 << (Q_W - 2));

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Bank command codes.
    localparam logic [1:0] CMD_ACC_A = 2'd0;
    localparam logic [1:0] CMD_MEAN  = 2'd1;
    localparam logic [1:0] CMD_ACC_B = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    typedef struct packed {
        logic        [1:0]       cmd;
        logic signed [SMP_W-1:0] in_x0;
        logic signed [SMP_W-1:0] in_x1;
        logic signed [SMP_W-1:0] in_x2;
        logic signed [SMP_W-1:0] in_x3;
        logic signed [SMP_W-1:0] in_y0;
        logic signed [SMP_W-1:0] in_y1;
    } item_t;

    typedef struct packed {
        logic        [1:0]       bank;
        logic signed [SUM_W-1:0] out_x0;
        logic signed [SUM_W-1:0] out_x1;
        logic signed [SUM_W-1:0] out_x2;
        logic signed [SUM_W-1:0] out_x3;
        logic signed [SUM_W-1:0] out_y0;
        logic signed [SUM_W-1:0] out_y1;
        logic        [TW_W-1:0]  total_weight;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             div_step;
        logic             mul_issue;
        logic [IDX_W-1:0] idx;
        logic             wb;
        logic             finish;
        logic             out_load;
    } ctrl_cmd_t;

endpackage

/* rtl/weighted_accumulator_and_running_mean.sv */
// Weighted accumulator and running mean over three banks. Banks A and B
// add weight times the primary 4-vector and the raw secondary 2-vector to
// saturating 48-bit sums; the mean bank moves each component toward the
// sample by weight / (total + weight). One item is worked at a time: an
// accumulate item makes six passes through the one shared 18x18 multiplier
// and a writeback, a running-mean item first runs the bit-serial divider,
// and an unused command goes straight to the handoff, which waits until the
// output register is free or being read. The next item is accepted in the
// cycle after that handoff, even while the previous result still waits in
// the output register. Configuration writes are always taken.
module weighted_accumulator_and_running_mean
    import wacc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [SMP_W-1:0] cfg_data,
    input  logic             item_valid,
    output logic             item_ready,
    input  item_t            item,
    output logic             result_valid,
    input  logic             result_ready,
    output result_t          result
);

    ctrl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    // Sequencer.
    wacc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_cmd     (item.cmd),
        .result_ready (result_ready),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    // Bank state, divider, multiplier and output register.
    wacc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .result    (result)
    );

endmodule

/* rtl/wacc_div.sv */
module wacc_div
    import wacc_pkg::*;
(
    input  logic             clk,
    input  logic             start,
    input  logic             step,
    input  logic [SMP_W-1:0] num,
    input  logic [TW_W:0]    den,
    output logic [Q_W-1:0]   quo
);

    // Restoring divider for (num << 16) / den, one quotient bit per step.
    // The quotient is known to fit in Q_W bits, so the partial remainder
    // starts with the numerator's top bits already loaded.
    logic [TW_W:0]    rem_reg;
    logic [TW_W:0]    rem_next;
    logic [Q_W-1:0]   bits_reg;
    logic [Q_W-1:0]   q_reg;
    logic [TW_W:0]    den_reg;
    logic [TW_W+1:0]  trial;
    logic [TW_W+1:0]  diff;
    logic             ge;

    always_comb
    begin
        trial    = {rem_reg, bits_reg[Q_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[TW_W:0] : trial[TW_W:0];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= (TW_W+1)'(num[SMP_W-1:1]);
            bits_reg <= {num[0], {(Q_W-1){1'b0}}};
            den_reg  <= den;
            q_reg    <= '0;
        end
        else if (step)
        begin
            rem_reg  <= rem_next;
            bits_reg <= {bits_reg[Q_W-2:0], 1'b0};
            q_reg    <= {q_reg[Q_W-2:0], ge};
        end
    end

    // A zero denominator leaves the means unchanged.
    assign quo = (den_reg == '0) ? '0 : q_reg;

endmodule

/* rtl/wacc_dp.sv */
module wacc_dp
    import wacc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [SMP_W-1:0] cfg_data,
    input  item_t            item,
    input  ctrl_cmd_t        cmd,
    output result_t          result
);

    logic [SMP_W-1:0]        weight_reg;
    logic [1:0]              bank_reg;
    logic signed [SMP_W-1:0] smp_reg  [0:NCOMP-1];
    logic signed [SUM_W-1:0] acc_reg  [0:1][0:NCOMP-1];
    logic signed [SMP_W-1:0] mean_reg [0:NCOMP-1];
    logic [TW_W-1:0]         wsum_reg [0:1];
    logic [TW_W-1:0]         mw_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  old_reg;
    logic [IDX_W-1:0]         idx_p_reg;
    logic signed [SUM_W-1:0]  work_reg [0:NCOMP-1];
    logic [TW_W-1:0]          work_tw_reg;
    result_t                  result_reg;

    logic                     is_mean;
    logic                     bsel;
    logic [TW_W:0]            den;
    logic [Q_W-1:0]           w_quo;
    logic signed [SMP_W-1:0]  x_cur;
    logic signed [SMP_W-1:0]  m_cur;
    logic signed [SMP_W:0]    diff;
    logic signed [MUL_W-1:0]  op_a;
    logic signed [MUL_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  old_next;
    logic signed [PROD_W-1:0] acc_rnd;
    logic signed [PROD_W-1:0] mean_rnd;
    logic signed [SUM_W:0]    sum_ext;
    logic signed [SUM_W-1:0]  sat_val;
    logic signed [SMP_W-1:0]  mean_new;
    logic signed [SUM_W-1:0]  wb_val;
    logic [TW_W-1:0]          w_old;
    logic [TW_W:0]            w_sum;
    logic [TW_W-1:0]          w_new;

    assign is_mean = (bank_reg == CMD_MEAN);
    assign bsel    = bank_reg[1];
    assign den     = {1'b0, mw_reg} + (TW_W+1)'(weight_reg);

    // Mean fraction w = weight / (total + weight).
    wacc_div u_div (
        .clk   (clk),
        .start (cmd.load),
        .step  (cmd.div_step),
        .num   (weight_reg),
        .den   (den),
        .quo   (w_quo)
    );

    // Multiply stage: operand selection for the shared multiplier.
    always_comb
    begin
        x_cur = smp_reg[cmd.idx];
        m_cur = mean_reg[cmd.idx];
        diff  = x_cur - m_cur;
        if (is_mean)
        begin
            op_a     = diff;
            op_b     = {1'b0, w_quo};
            old_next = m_cur;
        end
        else
        begin
            op_a     = x_cur;
            op_b     = (cmd.idx < IDX_W'(NPRI)) ? {2'b00, weight_reg} : UNIT_WEIGHT;
            old_next = acc_reg[bsel][cmd.idx];
        end
        prod = op_a * op_b;
    end

    // Writeback stage: round, then add with saturation or move the mean.
    always_comb
    begin
        acc_rnd  = (prod_reg + ACC_HALF) >>> FRAC_BITS;
        sum_ext  = old_reg + acc_rnd;
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
        begin
            sat_val = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sat_val = sum_ext[SUM_W-1:0];
        end
        mean_rnd = (prod_reg + MEAN_HALF) >>> (Q_W - 1);
        mean_new = old_reg[SMP_W-1:0] + mean_rnd[SMP_W-1:0];
        wb_val   = is_mean ? mean_new : sat_val;
    end

    // Saturating weight total.
    always_comb
    begin
        w_old = is_mean ? mw_reg : wsum_reg[bsel];
        w_sum = {1'b0, w_old} + (TW_W+1)'(weight_reg);
        w_new = w_sum[TW_W] ? {TW_W{1'b1}} : w_sum[TW_W-1:0];
    end

    // Bank state and the weight register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= SAMPLE_WEIGHT_RST;
            mw_reg     <= '0;
            for (int b = 0; b < 2; b++)
            begin
                wsum_reg[b] <= '0;
                for (int i = 0; i < NCOMP; i++)
                begin
                    acc_reg[b][i] <= '0;
                end
            end
            for (int i = 0; i < NCOMP; i++)
            begin
                mean_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                weight_reg <= cfg_data;
            end
            if (cmd.wb)
            begin
                if (is_mean)
                begin
                    mean_reg[idx_p_reg] <= mean_new;
                end
                else
                begin
                    acc_reg[bsel][idx_p_reg] <= sat_val;
                end
            end
            if (cmd.finish)
            begin
                if (is_mean)
                begin
                    mw_reg <= w_new;
                end
                else
                begin
                    wsum_reg[bsel] <= w_new;
                end
            end
        end
    end

    // Captured sample, pipeline registers and the result being built.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bank_reg    <= item.cmd;
            smp_reg[0]  <= item.in_x0;
            smp_reg[1]  <= item.in_x1;
            smp_reg[2]  <= item.in_x2;
            smp_reg[3]  <= item.in_x3;
            smp_reg[4]  <= item.in_y0;
            smp_reg[5]  <= item.in_y1;
            work_tw_reg <= '0;
            for (int i = 0; i < NCOMP; i++)
            begin
                work_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.wb)
            begin
                work_reg[idx_p_reg] <= wb_val;
            end
            if (cmd.finish)
            begin
                work_tw_reg <= w_new;
            end
        end
        if (cmd.mul_issue)
        begin
            prod_reg  <= prod;
            old_reg   <= old_next;
            idx_p_reg <= cmd.idx;
        end
        if (cmd.out_load)
        begin
            result_reg.bank         <= bank_reg;
            result_reg.out_x0       <= work_reg[0];
            result_reg.out_x1       <= work_reg[1];
            result_reg.out_x2       <= work_reg[2];
            result_reg.out_x3       <= work_reg[3];
            result_reg.out_y0       <= work_reg[4];
            result_reg.out_y1       <= work_reg[5];
            result_reg.total_weight <= work_tw_reg;
        end
    end

    assign result = result_reg;

endmodule

/* rtl/wacc_ctrl.sv */
module wacc_ctrl
    import wacc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic [1:0] item_cmd,
    input  logic      result_ready,
    output logic      item_ready,
    output logic      result_valid,
    output ctrl_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_TAIL = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // Sequencer: divide (mean only), six multiplies and writeback (not for the unused command), handoff.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (item_cmd == CMD_MEAN)
                    begin
                        state_next = S_DIV;
                    end
                    else if (item_cmd == CMD_NONE)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.mul_issue = 1'b1;
                cmd.idx       = cnt_reg[IDX_W-1:0];
                cmd.wb        = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(NCOMP - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_TAIL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_TAIL:
            begin
                cmd.wb     = 1'b1;
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register occupancy.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

endmodule

/* rtl/wacc_checker.sv */
module wacc_checker
    import wacc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    function automatic logic is_sext16(input logic [SUM_W-1:0] v);
        return (v[SUM_W-1:SMP_W-1] == '0) || (v[SUM_W-1:SMP_W-1] == '1);
    endfunction

    // A stalled transaction keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // The unused command reports an empty result.
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bank == CMD_NONE |->
            result.out_x0 == '0 && result.out_x1 == '0 && result.out_x2 == '0 &&
            result.out_x3 == '0 && result.out_y0 == '0 && result.out_y1 == '0 &&
            result.total_weight == '0)
        else $error("unused command returned nonzero fields");

    // Means are 16-bit values, sign extended.
    a_mean_width: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bank == CMD_MEAN |->
            is_sext16(result.out_x0) && is_sext16(result.out_x1) &&
            is_sext16(result.out_x2) && is_sext16(result.out_x3) &&
            is_sext16(result.out_y0) && is_sext16(result.out_y1))
        else $error("mean component exceeds 16 bits");

endmodule

bind weighted_accumulator_and_running_mean wacc_checker u_chk (.*);

/* sim/bank_update_checker.sv */
module bank_update_checker
    import wacc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [SMP_W-1:0] cfg_data,
    input  logic             item_valid,
    input  logic             item_ready,
    input  item_t            item,
    input  logic             result_valid,
    input  logic             result_ready,
    input  result_t          result,
    output int               failures,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the weight register and of all three banks.
    longint sample_wt;
    longint acc_primary [8];
    longint acc_secondary [4];
    longint acc_total [2];
    longint mean_primary [4];
    longint mean_secondary [2];
    longint mean_total;

    // Bank contents still owed by the block, oldest first.
    result_t pending_bank_states [$];
    int      mismatch_count;

    function automatic longint clamp_sum(longint v);
        if (v > longint'(SUM_MAX))
            return longint'(SUM_MAX);
        if (v < longint'(SUM_MIN))
            return longint'(SUM_MIN);
        return v;
    endfunction

    function automatic longint add_total(longint a, longint b);
        longint top;
        top = (longint'(1) << TW_W) - 1;
        return (a + b > top) ? top : a + b;
    endfunction

    // Move a mean toward the sample by the Q1.16 fraction, rounding half up.
    function automatic longint move_mean(longint m, longint x, longint frac);
        longint t;
        t = (x - m) * frac + 32768;
        return m + (t >>> 16);
    endfunction

    // Apply one transaction to the shadow banks and return the new bank contents.
    function automatic result_t predict_bank_update(item_t it);
        result_t r;
        longint  x [4];
        longint  y [2];
        longint  vals [6];
        longint  prod;
        longint  den;
        longint  frac;
        int      b;
        r = '0;
        r.bank = it.cmd;
        x[0] = it.in_x0;
        x[1] = it.in_x1;
        x[2] = it.in_x2;
        x[3] = it.in_x3;
        y[0] = it.in_y0;
        y[1] = it.in_y1;
        case (it.cmd)
            CMD_ACC_A, CMD_ACC_B:
            begin
                b = (it.cmd == CMD_ACC_B) ? 1 : 0;
                for (int i = 0; i < 4; i++)
                begin
                    prod = (sample_wt * x[i] + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
                    acc_primary[b*4+i] = clamp_sum(acc_primary[b*4+i] + prod);
                    vals[i] = acc_primary[b*4+i];
                end
                for (int i = 0; i < 2; i++)
                begin
                    acc_secondary[b*2+i] = clamp_sum(acc_secondary[b*2+i] + y[i]);
                    vals[4+i] = acc_secondary[b*2+i];
                end
                acc_total[b] = add_total(acc_total[b], sample_wt);
                r.total_weight = acc_total[b];
            end
            CMD_MEAN:
            begin
                // A zero denominator leaves the means where they are.
                den = mean_total + sample_wt;
                frac = (den != 0) ? (sample_wt << 16) / den : 0;
                for (int i = 0; i < 4; i++)
                begin
                    mean_primary[i] = move_mean(mean_primary[i], x[i], frac);
                    vals[i] = mean_primary[i];
                end
                for (int i = 0; i < 2; i++)
                begin
                    mean_secondary[i] = move_mean(mean_secondary[i], y[i], frac);
                    vals[4+i] = mean_secondary[i];
                end
                mean_total = add_total(mean_total, sample_wt);
                r.total_weight = mean_total;
            end
            default:
            begin
                // The unused command touches nothing and reports zeros.
                return r;
            end
        endcase
        r.out_x0 = vals[0];
        r.out_x1 = vals[1];
        r.out_x2 = vals[2];
        r.out_x3 = vals[3];
        r.out_y0 = vals[4];
        r.out_y1 = vals[5];
        return r;
    endfunction

    task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_bank_state(result_t want, result_t got);
        check_field("bank", want.bank, got.bank);
        check_field("out_x0", want.out_x0, got.out_x0);
        check_field("out_x1", want.out_x1, got.out_x1);
        check_field("out_x2", want.out_x2, got.out_x2);
        check_field("out_x3", want.out_x3, got.out_x3);
        check_field("out_y0", want.out_y0, got.out_y0);
        check_field("out_y1", want.out_y1, got.out_y1);
        check_field("total_weight", want.total_weight, got.total_weight);
    endtask

    // Watch all three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_wt = longint'(SAMPLE_WEIGHT_RST);
            foreach (acc_primary[i]) acc_primary[i] = 0;
            foreach (acc_secondary[i]) acc_secondary[i] = 0;
            foreach (acc_total[i]) acc_total[i] = 0;
            foreach (mean_primary[i]) mean_primary[i] = 0;
            foreach (mean_secondary[i]) mean_secondary[i] = 0;
            mean_total = 0;
            pending_bank_states.delete();
            mismatch_count = 0;
            failures <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                sample_wt = longint'(cfg_data);
            if (item_valid && item_ready)
                pending_bank_states.push_back(predict_bank_update(item));
            if (result_valid && result_ready)
            begin
                if (pending_bank_states.size() == 0)
                begin
                    $error("Result transaction with no bank update outstanding");
                    mismatch_count++;
                end
                else
                begin
                    check_bank_state(pending_bank_states.pop_front(), result);
                end
            end
            outstanding <= pending_bank_states.size();
            failures <= mismatch_count;
        end
    end

endmodule

/* sim/weighted_accumulator_and_running_mean_tb.sv */
module weighted_accumulator_and_running_mean_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wacc_pkg::*;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [SMP_W-1:0] cfg_data = '0;
    logic             item_valid = 1'b0;
    logic             item_ready;
    item_t            item = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    result_t          result;
    int               failures;
    int               outstanding;

    // Stretches with no idling on either side.
    bit               send_steady = 1'b0;
    bit               take_steady = 1'b0;

    always #2 clk = ~clk;

    weighted_accumulator_and_running_mean dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    bank_update_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    // Write the sample weight register.
    task automatic write_weight(logic [SMP_W-1:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Offer one sample transaction after a random gap; valid stays up afterwards.
    task automatic send_sample(item_t it);
        int gap;
        if ($urandom_range(0, 49) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
    endtask

    // Stop sending and hold off until every bank update has come back.
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic item_t make_sample(logic [1:0] cmd,
                                          logic [15:0] x0, logic [15:0] x1,
                                          logic [15:0] x2, logic [15:0] x3,
                                          logic [15:0] y0, logic [15:0] y1);
        item_t it;
        it.cmd = cmd;
        it.in_x0 = x0;
        it.in_x1 = x1;
        it.in_x2 = x2;
        it.in_x3 = x3;
        it.in_y0 = y0;
        it.in_y1 = y1;
        return it;
    endfunction

    // Mix of extremes, small values near zero and full-range values.
    function automatic logic [15:0] random_component();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic item_t random_sample();
        logic [1:0] cmd;
        int         pick;
        pick = $urandom_range(0, 15);
        if (pick < 5)
            cmd = CMD_ACC_A;
        else if (pick < 10)
            cmd = CMD_MEAN;
        else if (pick < 15)
            cmd = CMD_ACC_B;
        else
            cmd = CMD_NONE;
        return make_sample(cmd, random_component(), random_component(),
                           random_component(), random_component(),
                           random_component(), random_component());
    endfunction

    // Result side: random stall before each result, never lowering ready and
    // raising it again in one step.
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                take_steady = !take_steady;
            stall = take_steady ? 0 : $urandom_range(0, 5);
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!(result_valid && result_ready));
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic [15:0] phase_weights [9];
        phase_weights = '{16'd256, 16'hFFFF, 16'd0, 16'd1, 16'd128,
                          16'($urandom), 16'd512, 16'($urandom), 16'($urandom)};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero weight on empty banks: the mean sees a zero denominator.
        write_weight(16'd0);
        send_sample(make_sample(CMD_MEAN, 16'd100, -16'sd100, 16'h7FFF, 16'h8000,
                                16'd5, -16'sd5));
        send_sample(make_sample(CMD_ACC_A, 16'h7FFF, 16'h8000, 16'd1, 16'hFFFF,
                                16'h7FFF, 16'h8000));
        send_sample(make_sample(CMD_ACC_B, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd1,
                                16'h8000, 16'h7FFF));
        drain_results();

        // Unit weight: first mean sample is taken exactly, then large swings.
        write_weight(16'd256);
        send_sample(make_sample(CMD_MEAN, 16'h7FFF, 16'h8000, 16'd0, 16'hFFFF,
                                16'h7FFF, 16'h8000));
        send_sample(make_sample(CMD_MEAN, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd0,
                                16'h8000, 16'h7FFF));
        send_sample(make_sample(CMD_MEAN, 16'd3, -16'sd3, 16'd1, -16'sd1, 16'd2, -16'sd2));
        send_sample(make_sample(CMD_ACC_A, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                                16'h7FFF, 16'h8000));
        send_sample(make_sample(CMD_ACC_B, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                                16'h8000, 16'h7FFF));
        send_sample(make_sample(CMD_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 16'hFFFF));
        drain_results();

        // Largest weight.
        write_weight(16'hFFFF);
        send_sample(make_sample(CMD_ACC_A, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                16'h7FFF, 16'h7FFF));
        send_sample(make_sample(CMD_ACC_A, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                16'h8000, 16'h8000));
        send_sample(make_sample(CMD_ACC_B, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd1,
                                16'd0, 16'hFFFF));
        send_sample(make_sample(CMD_MEAN, 16'h7FFF, 16'h8000, 16'd0, 16'd77,
                                16'h7FFF, 16'h8000));
        send_sample(make_sample(CMD_MEAN, 16'h8000, 16'h7FFF, 16'd1, -16'sd77,
                                16'd0, 16'd0));
        send_sample(make_sample(CMD_NONE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        drain_results();

        // Tiny weight: rounding of the weighted product around half an LSB.
        write_weight(16'd1);
        send_sample(make_sample(CMD_ACC_A, 16'd1, -16'sd1, 16'd128, -16'sd128,
                                16'd1, -16'sd1));
        send_sample(make_sample(CMD_ACC_B, 16'd127, -16'sd129, 16'd129, -16'sd127,
                                16'd0, 16'd0));
        send_sample(make_sample(CMD_MEAN, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                                16'h7FFF, 16'h8000));
        drain_results();

        // Random phases, each under its own weight, draining in between.
        foreach (phase_weights[p])
        begin
            write_weight(phase_weights[p]);
            repeat (156) send_sample(random_sample());
            drain_results();
        end

        repeat (40) @(posedge clk);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/wacc_pkg.sv
rtl/wacc_div.sv
rtl/wacc_dp.sv
rtl/wacc_ctrl.sv
rtl/weighted_accumulator_and_running_mean.sv
rtl/wacc_checker.sv
sim/bank_update_checker.sv
sim/weighted_accumulator_and_running_mean_tb.sv
